/* rtl/assert_macros.svh */
// Assertion macros shared by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/cadc_pkg.sv */
// Shared types and constants of the catapult and drive controller.
package cadc_pkg;

  localparam int DRIVE_W    = 8;
  localparam int TIMER_W    = 16;
  localparam int LEVEL_W    = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [DRIVE_W-1:0] FULL_DRIVE = DRIVE_W'(127);
  localparam logic signed [DRIVE_W-1:0] NEG_DRIVE  = -DRIVE_W'(127);
  localparam logic signed [DRIVE_W-1:0] ZERO_DRIVE = '0;

  // Catapult mode codes.
  localparam logic [1:0] MODE_MOVING = 2'd0;
  localparam logic [1:0] MODE_HALTED = 2'd1;
  localparam logic [1:0] MODE_READY  = 2'd2;
  localparam logic [1:0] MODE_FIRING = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_TIMEOUT = 3'd4;

  typedef struct packed {
    logic       cat_up;
    logic       cat_down;
    logic       cat_reset;
    logic       hang_up;
    logic       hang_down;
    logic       cat_limit;
    logic       upper_limit;
    logic [7:0] elapsed_ms;
  } cadc_cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] stick_deadband;
    logic [LEVEL_W-1:0] turn_drive_level;
    logic [LEVEL_W-1:0] drive_limit;
    logic [TIMER_W-1:0] settle_time_ms;
    logic [TIMER_W-1:0] fire_timeout_ms;
  } cadc_cfg_t;

endpackage

/* rtl/cadc_drive_mix.sv */
// Drive mixing: deadband, arcade mix, clamp, slow halving and button turns.
module cadc_drive_mix
  import cadc_pkg::*;
(
  input  logic signed [7:0]         forward_axis,
  input  logic signed [7:0]         turn_axis,
  input  logic                      turn_right_button,
  input  logic                      turn_left_button,
  input  logic                      slow_button,
  input  cadc_cfg_t                 cfg,
  output logic signed [DRIVE_W-1:0] left_drive,
  output logic signed [DRIVE_W-1:0] right_drive
);

  logic signed [8:0]  fwd_ext, turn_ext, fwd_mag, turn_mag, fwd_sh, turn_sh;
  logic signed [9:0]  sum_l, sum_r, lim10, clamp_l, clamp_r, half_l, half_r;
  logic signed [DRIVE_W-1:0] turn_lvl;

  assign fwd_ext  = 9'(forward_axis);
  assign turn_ext = 9'(turn_axis);
  assign fwd_mag  = fwd_ext[8] ? -fwd_ext : fwd_ext;
  assign turn_mag = turn_ext[8] ? -turn_ext : turn_ext;

  // Sticks are wired inverted, so a live axis is negated.
  assign fwd_sh  = (fwd_mag < signed'({2'b00, cfg.stick_deadband})) ? '0 : -fwd_ext;
  assign turn_sh = (turn_mag < signed'({2'b00, cfg.stick_deadband})) ? '0 : -turn_ext;

  assign sum_l = 10'(fwd_sh) + 10'(turn_sh);
  assign sum_r = 10'(fwd_sh) - 10'(turn_sh);
  assign lim10 = signed'({3'b000, cfg.drive_limit});

  always_comb begin
    clamp_l = sum_l;
    if (sum_l > lim10) clamp_l = lim10;
    else if (sum_l < -lim10) clamp_l = -lim10;
    clamp_r = sum_r;
    if (sum_r > lim10) clamp_r = lim10;
    else if (sum_r < -lim10) clamp_r = -lim10;
  end

  // Halving rounds toward zero: bias negative values by one before the shift.
  assign half_l = slow_button ? ((clamp_l + signed'(10'(clamp_l[9]))) >>> 1) : clamp_l;
  assign half_r = slow_button ? ((clamp_r + signed'(10'(clamp_r[9]))) >>> 1) : clamp_r;

  assign turn_lvl = signed'({1'b0, cfg.turn_drive_level});

  always_comb begin
    if (turn_left_button) begin
      left_drive  = -turn_lvl;
      right_drive = turn_lvl;
    end else if (turn_right_button) begin
      left_drive  = turn_lvl;
      right_drive = -turn_lvl;
    end else begin
      left_drive  = half_l[DRIVE_W-1:0];
      right_drive = half_r[DRIVE_W-1:0];
    end
  end

endmodule

/* rtl/cadc_cat_fsm.sv */
// Catapult mode machine with settle and fire timers, plus held hang drive.
module cadc_cat_fsm
  import cadc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  cadc_cmd_t                 cmd,
  input  cadc_cfg_t                 cfg,
  output logic signed [DRIVE_W-1:0] cat_drive_nxt,
  output logic signed [DRIVE_W-1:0] hang_drive_nxt,
  output logic [1:0]                mode_nxt
);

  logic [1:0]                mode_r;
  logic [TIMER_W-1:0]        settle_timer_r, settle_timer_nxt;
  logic [TIMER_W-1:0]        fire_timer_r, fire_timer_nxt;
  logic signed [DRIVE_W-1:0] cat_drive_r, hang_drive_r;
  logic [TIMER_W:0]          settle_sum, fire_sum;
  logic [TIMER_W-1:0]        settle_sat, fire_sat;

  assign settle_sum = {1'b0, settle_timer_r} + (TIMER_W+1)'(cmd.elapsed_ms);
  assign fire_sum   = {1'b0, fire_timer_r} + (TIMER_W+1)'(cmd.elapsed_ms);
  assign settle_sat = settle_sum[TIMER_W] ? '1 : settle_sum[TIMER_W-1:0];
  assign fire_sat   = fire_sum[TIMER_W] ? '1 : fire_sum[TIMER_W-1:0];

  always_comb begin
    mode_nxt         = mode_r;
    settle_timer_nxt = settle_timer_r;
    fire_timer_nxt   = fire_timer_r;
    cat_drive_nxt    = cat_drive_r;
    if (mode_r == MODE_FIRING) begin
      fire_timer_nxt = fire_sat;
      if (!cmd.cat_limit || fire_sat > cfg.fire_timeout_ms) begin
        cat_drive_nxt = ZERO_DRIVE;
        mode_nxt      = cmd.cat_limit ? MODE_READY : MODE_MOVING;
      end
    end else begin
      if (cmd.cat_reset && !cmd.cat_limit) cat_drive_nxt = FULL_DRIVE;
      unique case (mode_r)
        MODE_MOVING: begin
          if (cmd.cat_down) cat_drive_nxt = FULL_DRIVE;
          else if (cmd.cat_up) begin
            if (!cmd.upper_limit) cat_drive_nxt = NEG_DRIVE;
          end else cat_drive_nxt = ZERO_DRIVE;
          if (cmd.cat_limit) begin
            cat_drive_nxt    = ZERO_DRIVE;
            mode_nxt         = MODE_HALTED;
            settle_timer_nxt = '0;
          end
        end
        MODE_HALTED: begin
          settle_timer_nxt = settle_sat;
          if (!cmd.cat_down) begin
            if (settle_sat > cfg.settle_time_ms) mode_nxt = MODE_READY;
          end else if (cmd.cat_up) begin
            if (!cmd.upper_limit) cat_drive_nxt = NEG_DRIVE;
          end else cat_drive_nxt = ZERO_DRIVE;
          if (!cmd.cat_limit) mode_nxt = MODE_MOVING;
        end
        default: begin
          // Ready: a down press starts a shot when the catapult sits on its switch.
          if (cmd.cat_down) begin
            fire_timer_nxt = '0;
            if (cmd.cat_limit) begin
              cat_drive_nxt = FULL_DRIVE;
              mode_nxt      = MODE_FIRING;
            end else cat_drive_nxt = ZERO_DRIVE;
          end else if (cmd.cat_up) begin
            if (!cmd.upper_limit) cat_drive_nxt = NEG_DRIVE;
          end else cat_drive_nxt = ZERO_DRIVE;
          if (!cmd.cat_limit) mode_nxt = MODE_MOVING;
        end
      endcase
    end
  end

  always_comb begin
    hang_drive_nxt = hang_drive_r;
    if (cmd.hang_up && !cmd.hang_down) hang_drive_nxt = FULL_DRIVE;
    else if (cmd.hang_down && !cmd.hang_up) hang_drive_nxt = NEG_DRIVE;
    else if (!cmd.hang_down && !cmd.hang_up) hang_drive_nxt = ZERO_DRIVE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_MOVING;
      settle_timer_r <= '0;
      fire_timer_r   <= '0;
      cat_drive_r    <= ZERO_DRIVE;
      hang_drive_r   <= ZERO_DRIVE;
    end else if (adv) begin
      mode_r         <= mode_nxt;
      settle_timer_r <= settle_timer_nxt;
      fire_timer_r   <= fire_timer_nxt;
      cat_drive_r    <= cat_drive_nxt;
      hang_drive_r   <= hang_drive_nxt;
    end
  end

endmodule

/* rtl/catapult_and_drive_controller_core.sv */
// Top level of the catapult and drive controller.
// Usage:
//   One input word on the in_ stream is one control period: stick axes,
//   buttons, limit switches and elapsed milliseconds. Each word yields exactly
//   one output word on the out_ stream with left, right, catapult and hang
//   drive and the catapult mode.
//   An accepted word is held in the input register and then computed into the
//   output register, which drives out_tvalid. One word is accepted per cycle
//   while out_tready stays high. When the receiver stalls, the result is held
//   in the output register and one more word waits in the input register;
//   in_tready then drops. The cfg_ port writes the five tuning registers and
//   is always ready; write it only while no word is in flight.
//   Reset (rst_n low, synchronous) empties both registers, sets the mode to
//   moving, clears timers and held drives, and restores the register
//   defaults: deadband 25, turn level 32, drive limit 96, settle 150 ms,
//   fire timeout 50 ms.
`include "assert_macros.svh"

module catapult_and_drive_controller_core
  import cadc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // forward_axis[7:0], turn_axis[15:8], cat_up_button[16], cat_down_button[17],
  // cat_reset_button[18], hang_up_button[19], hang_down_button[20],
  // turn_right_button[21], turn_left_button[22], slow_button[23],
  // limit_switches[25:24], elapsed_ms[33:26], zeros above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // left_drive[7:0], right_drive[15:8], catapult_drive[23:16], hang_drive[31:24],
  // catapult_mode[33:32], zeros above
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                      in_valid_r, out_valid_r, adv;
  logic [33:0]               in_data_r;
  logic [33:0]               out_data_r;
  cadc_cfg_t                 cfg_r;
  cadc_cmd_t                 cmd;
  logic signed [DRIVE_W-1:0] left_drive, right_drive, cat_drive, hang_drive;
  logic [1:0]                mode;

  // The stage moves when there is a word and the output register is free.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_data_r <= in_tdata[33:0];
    if (adv) out_data_r <= {mode, hang_drive, cat_drive, right_drive, left_drive};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_deadband   <= LEVEL_W'(25);
      cfg_r.turn_drive_level <= LEVEL_W'(32);
      cfg_r.drive_limit      <= LEVEL_W'(96);
      cfg_r.settle_time_ms   <= TIMER_W'(150);
      cfg_r.fire_timeout_ms  <= TIMER_W'(50);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEADBAND:     cfg_r.stick_deadband   <= cfg_data[LEVEL_W-1:0];
        REG_TURN_LEVEL:   cfg_r.turn_drive_level <= cfg_data[LEVEL_W-1:0];
        REG_DRIVE_LIMIT:  cfg_r.drive_limit      <= cfg_data[LEVEL_W-1:0];
        REG_SETTLE_TIME:  cfg_r.settle_time_ms   <= cfg_data[TIMER_W-1:0];
        REG_FIRE_TIMEOUT: cfg_r.fire_timeout_ms  <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd.cat_up      = in_data_r[16];
  assign cmd.cat_down    = in_data_r[17];
  assign cmd.cat_reset   = in_data_r[18];
  assign cmd.hang_up     = in_data_r[19];
  assign cmd.hang_down   = in_data_r[20];
  assign cmd.cat_limit   = in_data_r[24];
  assign cmd.upper_limit = in_data_r[25];
  assign cmd.elapsed_ms  = in_data_r[33:26];

  cadc_cat_fsm u_cat_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .cmd            (cmd),
    .cfg            (cfg_r),
    .cat_drive_nxt  (cat_drive),
    .hang_drive_nxt (hang_drive),
    .mode_nxt       (mode)
  );

  cadc_drive_mix u_drive_mix (
    .forward_axis      (in_data_r[7:0]),
    .turn_axis         (in_data_r[15:8]),
    .turn_right_button (in_data_r[21]),
    .turn_left_button  (in_data_r[22]),
    .slow_button       (in_data_r[23]),
    .cfg               (cfg_r),
    .left_drive        (left_drive),
    .right_drive       (right_drive)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-34){1'b0}}, out_data_r};

  `ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "output valid after reset")
  `ASSERT_CLK(a_adv_fills, adv |=> out_tvalid, "computed word not presented")
  `ASSERT_CLK(a_fire_drive,
              out_tvalid && out_tdata[33:32] == MODE_FIRING |-> out_tdata[23:16] == FULL_DRIVE,
              "firing mode without full catapult drive")
  `ASSERT_CLK(a_drive_range,
              out_tvalid |-> out_tdata[7:0] != 8'h80 && out_tdata[15:8] != 8'h80,
              "drive outside symmetric range")

endmodule

/* bench/testbench.sv */
// Self-checking bench for the catapult and drive controller: a directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import cadc_pkg::*;

  // Button bits in the order they sit in the input word.
  localparam logic [7:0] BTN_NONE  = 8'h00;
  localparam logic [7:0] BTN_UP    = 8'h01;
  localparam logic [7:0] BTN_DOWN  = 8'h02;
  localparam logic [7:0] BTN_RESET = 8'h04;
  localparam logic [7:0] BTN_HUP   = 8'h08;
  localparam logic [7:0] BTN_HDN   = 8'h10;
  localparam logic [7:0] BTN_TR    = 8'h20;
  localparam logic [7:0] BTN_TL    = 8'h40;
  localparam logic [7:0] BTN_SLOW  = 8'h80;

  localparam logic [1:0] LIM_OPEN  = 2'b00;
  localparam logic [1:0] LIM_CAT   = 2'b01;
  localparam logic [1:0] LIM_UPPER = 2'b10;
  localparam logic [1:0] LIM_BOTH  = 2'b11;

  typedef struct packed {
    logic signed [7:0] fwd;
    logic signed [7:0] turn;
    logic [7:0]        btn;
    logic [1:0]        lim;
    logic [7:0]        dt;
  } ctrl_item_t;

  typedef struct packed {
    logic signed [7:0] left;
    logic signed [7:0] right;
    logic signed [7:0] cat;
    logic signed [7:0] hang;
    logic [1:0]        mode;
  } motor_cmd_t;

  typedef struct packed {
    ctrl_item_t item;
    logic       given;
    motor_cmd_t want;
  } drill_row_t;

  localparam motor_cmd_t NO_CMD = '0;

  // Rows with given set carry a result that is plain from the defaults; the rest are predicted.
  localparam drill_row_t DRILL [0:26] = '{
    '{'{8'sd0, 8'sd0, BTN_NONE, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    // Most negative forward axis, clamped to the drive limit.
    '{'{8'sh80, 8'sd0, BTN_NONE, LIM_OPEN, 8'd0},
      1'b1, '{8'sd96, 8'sd96, ZERO_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd127, 8'sh80, BTN_SLOW, LIM_OPEN, 8'd0},
      1'b1, '{8'sd0, -8'sd48, ZERO_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd25, -8'sd24, BTN_NONE, LIM_OPEN, 8'd0},
      1'b1, '{-8'sd25, -8'sd25, ZERO_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd100, 8'sd0, BTN_TL | BTN_TR, LIM_OPEN, 8'd0},
      1'b1, '{-8'sd32, 8'sd32, ZERO_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_TR, LIM_OPEN, 8'd0},
      1'b1, '{8'sd32, -8'sd32, ZERO_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_HUP, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, FULL_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_HUP | BTN_HDN, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, FULL_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_HDN, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, NEG_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_DOWN, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, FULL_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_UP, LIM_UPPER, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, FULL_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_UP, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, NEG_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_NONE, LIM_CAT, 8'd255},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, MODE_HALTED}},
    '{'{8'sd0, 8'sd0, BTN_DOWN | BTN_UP, LIM_CAT, 8'd100}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_DOWN, LIM_CAT, 8'd100}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_NONE, LIM_CAT, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, MODE_READY}},
    '{'{8'sd0, 8'sd0, BTN_UP, LIM_BOTH, 8'd0}, 1'b0, NO_CMD},
    // Fire request with the catapult limit already open.
    '{'{8'sd0, 8'sd0, BTN_DOWN, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, ZERO_DRIVE, MODE_MOVING}},
    '{'{8'sd0, 8'sd0, BTN_NONE, LIM_CAT, 8'd255}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_NONE, LIM_CAT, 8'd255}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_DOWN, LIM_CAT, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, FULL_DRIVE, ZERO_DRIVE, MODE_FIRING}},
    '{'{8'sd0, 8'sd0, BTN_RESET | BTN_UP, LIM_CAT, 8'd30}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_NONE, LIM_CAT, 8'd30}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_DOWN, LIM_CAT, 8'd0}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_HUP | BTN_TL, LIM_OPEN, 8'd0}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_RESET, LIM_CAT, 8'd0}, 1'b0, NO_CMD},
    '{'{8'sd0, 8'sd0, BTN_RESET, LIM_OPEN, 8'd0},
      1'b1, '{ZERO_DRIVE, ZERO_DRIVE, FULL_DRIVE, ZERO_DRIVE, MODE_MOVING}}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit calm;

  // Predictor state and its copy of the tuning registers.
  logic [1:0]         cat_mode;
  logic [TIMER_W-1:0] settle_ms;
  logic [TIMER_W-1:0] fire_ms;
  logic signed [7:0]  held_cat;
  logic signed [7:0]  held_hang;
  logic [LEVEL_W-1:0] dead_band;
  logic [LEVEL_W-1:0] turn_level;
  logic [LEVEL_W-1:0] drive_lim;
  logic [TIMER_W-1:0] settle_limit;
  logic [TIMER_W-1:0] fire_limit;

  motor_cmd_t  pending_cmds [$];
  int unsigned mismatches;
  int unsigned words_seen;

  catapult_and_drive_controller_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit take_break();
    return !calm && chance(8);
  endfunction

  function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
                                                 input logic [7:0] d);
    logic [TIMER_W:0] sum;
    sum = {1'b0, t} + {{(TIMER_W-7){1'b0}}, d};
    return sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
  endfunction

  // An axis inside the deadband reads as zero; outside it the sign is flipped.
  function automatic int shape_axis(input logic signed [7:0] a);
    int v;
    v = a;
    return (((v < 0) ? -v : v) < int'(dead_band)) ? 0 : -v;
  endfunction

  function automatic int clamp_drive(input int v);
    int lim;
    lim = int'(drive_lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic motor_cmd_t predict_motors(input ctrl_item_t it);
    motor_cmd_t res;
    logic up, down, rst_req, hup, hdn, tr, tl, slow, cat_lim, upper_lim;
    int y, z, left_v, right_v, t;
    {slow, tl, tr, hdn, hup, rst_req, down, up} = it.btn;
    cat_lim = it.lim[0];
    upper_lim = it.lim[1];

    if (cat_mode == MODE_FIRING) begin
      // Buttons are ignored while firing; only the limit and the timeout end it.
      fire_ms = sat_add(fire_ms, it.dt);
      if (!cat_lim || fire_ms > fire_limit) begin
        held_cat = ZERO_DRIVE;
        cat_mode = cat_lim ? MODE_READY : MODE_MOVING;
      end
    end else begin
      if (rst_req && !cat_lim) held_cat = FULL_DRIVE;
      case (cat_mode)
        MODE_MOVING: begin
          if (down) held_cat = FULL_DRIVE;
          else if (up) begin
            if (!upper_lim) held_cat = NEG_DRIVE;
          end else held_cat = ZERO_DRIVE;
          if (cat_lim) begin
            held_cat = ZERO_DRIVE;
            cat_mode = MODE_HALTED;
            settle_ms = '0;
          end
        end
        MODE_HALTED: begin
          settle_ms = sat_add(settle_ms, it.dt);
          if (!down) begin
            if (settle_ms > settle_limit) cat_mode = MODE_READY;
          end else if (up) begin
            if (!upper_lim) held_cat = NEG_DRIVE;
          end else held_cat = ZERO_DRIVE;
          if (!cat_lim) cat_mode = MODE_MOVING;
        end
        default: begin
          if (down) begin
            fire_ms = '0;
            if (cat_lim) begin
              held_cat = FULL_DRIVE;
              cat_mode = MODE_FIRING;
            end else held_cat = ZERO_DRIVE;
          end else if (up) begin
            if (!upper_lim) held_cat = NEG_DRIVE;
          end else held_cat = ZERO_DRIVE;
          if (!cat_lim) cat_mode = MODE_MOVING;
        end
      endcase
    end

    if (hup && !hdn) held_hang = FULL_DRIVE;
    else if (hdn && !hup) held_hang = NEG_DRIVE;
    else if (!hdn && !hup) held_hang = ZERO_DRIVE;

    if (tl || tr) begin
      t = int'(turn_level);
      left_v = tl ? -t : t;
      right_v = tl ? t : -t;
    end else begin
      y = shape_axis(it.fwd);
      z = shape_axis(it.turn);
      left_v = clamp_drive(y + z);
      right_v = clamp_drive(y - z);
      if (slow) begin
        left_v = left_v / 2;
        right_v = right_v / 2;
      end
    end

    res.left = 8'(left_v);
    res.right = 8'(right_v);
    res.cat = held_cat;
    res.hang = held_hang;
    res.mode = cat_mode;
    return res;
  endfunction

  // Axis values cluster around the deadband edge a quarter of the time.
  function automatic logic signed [7:0] rand_axis();
    int m;
    m = int'(dead_band) + int'($urandom_range(4)) - 2;
    if (chance(50)) m = -m;
    return chance(25) ? 8'(m) : 8'($urandom);
  endfunction

  function automatic ctrl_item_t rand_item(input int unsigned open_pct, input bit long_steps);
    ctrl_item_t it;
    it.fwd = rand_axis();
    it.turn = rand_axis();
    it.btn = {chance(40), chance(12), chance(12), chance(30),
              chance(30), chance(15), chance(25), chance(25)};
    it.lim = {chance(50), !chance(open_pct)};
    if (long_steps) it.dt = 8'd255;
    else it.dt = chance(70) ? 8'($urandom_range(60)) : 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input ctrl_item_t it, input logic given, input motor_cmd_t want);
    motor_cmd_t model_cmd;
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, it.dt, it.lim, it.btn, it.turn, it.fwd};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    model_cmd = predict_motors(it);
    pending_cmds.push_back(given ? want : model_cmd);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes never drop and raise it between them.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      REG_DEADBAND:     dead_band = val[LEVEL_W-1:0];
      REG_TURN_LEVEL:   turn_level = val[LEVEL_W-1:0];
      REG_DRIVE_LIMIT:  drive_lim = val[LEVEL_W-1:0];
      REG_SETTLE_TIME:  settle_limit = val;
      REG_FIRE_TIMEOUT: fire_limit = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [6:0] dead, input logic [6:0] turn_lvl,
                              input logic [6:0] lim, input logic [15:0] settle,
                              input logic [15:0] timeout);
    write_reg(REG_DEADBAND, {9'b0, dead});
    write_reg(REG_TURN_LEVEL, {9'b0, turn_lvl});
    write_reg(REG_DRIVE_LIMIT, {9'b0, lim});
    write_reg(REG_SETTLE_TIME, settle);
    write_reg(REG_FIRE_TIMEOUT, timeout);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned open_pct,
                            input bit long_steps);
    for (int unsigned n = 0; n < count; n++) begin
      send_item(rand_item(open_pct, long_steps), 1'b0, NO_CMD);
      if (chance(3)) drain_results();
    end
    drain_results();
  endtask

  always @(posedge clk) out_tready <= !take_break();

  // Both handshakes are judged at the falling edge, where every input is settled.
  always @(negedge clk) begin : check_words
    motor_cmd_t got;
    motor_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.left = out_tdata[7:0];
      got.right = out_tdata[15:8];
      got.cat = out_tdata[23:16];
      got.hang = out_tdata[31:24];
      got.mode = out_tdata[33:32];
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("word %0d arrived with nothing expected", words_seen);
      end else begin
        want = pending_cmds.pop_front();
        if (got.left != want.left || got.right != want.right || got.cat != want.cat ||
            got.hang != want.hang || got.mode != want.mode) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected L %0d R %0d C %0d H %0d M %0d, got L %0d R %0d C %0d H %0d M %0d",
                     words_seen, want.left, want.right, want.cat, want.hang, want.mode,
                     got.left, got.right, got.cat, got.hang, got.mode);
        end
      end
      words_seen++;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEADBAND;
    cfg_data = '0;
    calm = 1'b0;
    mismatches = 0;
    words_seen = 0;
    cat_mode = MODE_MOVING;
    settle_ms = '0;
    fire_ms = '0;
    held_cat = ZERO_DRIVE;
    held_hang = ZERO_DRIVE;
    dead_band = 7'd25;
    turn_level = 7'd32;
    drive_lim = 7'd96;
    settle_limit = 16'd150;
    fire_limit = 16'd50;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DRILL[i]) send_item(DRILL[i].item, DRILL[i].given, DRILL[i].want);
    drain_results();

    program_regs(7'($urandom_range(60)), 7'($urandom), 7'($urandom),
                 16'($urandom_range(300)), 16'($urandom_range(200)));
    run_random(25, 10, 1'b0);

    program_regs(7'd0, 7'd0, 7'd0, 16'd0, 16'd0);
    run_random(20, 15, 1'b0);

    // Limit held closed with long steps: the settle timer runs into saturation.
    calm = 1'b1;
    program_regs(7'd127, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF);
    run_random(262, 0, 1'b1);
    calm = 1'b0;

    // Ready comes at once, and firing then runs on while the fire timer saturates.
    program_regs(7'($urandom), 7'($urandom), 7'($urandom), 16'd0, 16'hFFFF);
    run_random(280, 0, 1'b1);

    program_regs(7'd25, 7'($urandom), 7'($urandom_range(64, 127)),
                 16'($urandom_range(40, 200)), 16'($urandom_range(20, 100)));
    run_random(25, 10, 1'b0);

    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/cadc_pkg.sv
rtl/cadc_drive_mix.sv
rtl/cadc_cat_fsm.sv
rtl/catapult_and_drive_controller_core.sv
bench/testbench.sv
